// File: design/cau_pkg.sv
package cau_pkg;

  localparam int CAU_FRAC_BITS = 16;
  localparam int DIV_STEPS     = 32;
  // Partial remainder width: covers a 64-bit magnitude shifted by up to 32 bits
  // and the divisor shifted by the quotient width.
  localparam int REM_W         = 96;

  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_MUL  = 2'd1,
    MODE_DIV  = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] a_re;
    logic [31:0] a_im;
    logic [31:0] b_re;
    logic [31:0] b_im;
  } op_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] a_re;
    logic [31:0] a_im;
    logic [32:0] sum_re;
    logic [32:0] sum_im;
    logic [63:0] p_rr;
    logic [63:0] p_ii;
    logic [63:0] p_ri;
    logic [63:0] p_ir;
    logic [63:0] p_br2;
    logic [63:0] p_bi2;
  } prod_t;

  typedef struct packed {
    logic             neg;
    logic             big;
    logic [REM_W-1:0] r;
    logic [31:0]      q;
  } lane_t;

  typedef struct packed {
    logic        do_div;
    logic [31:0] early_re;
    logic [31:0] early_im;
    logic        early_dz;
    logic        early_ovf;
    logic [63:0] den;
    lane_t       re;
    lane_t       im;
  } div_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] val;
  } sat_t;

  function automatic sat_t sat_fn(input logic neg, input logic [64:0] mag);
    sat_t s;
    s.ovf = 1'b0;
    if (!neg) begin
      if (mag > 65'h0_7FFF_FFFF) begin
        s.ovf = 1'b1;
        s.val = 32'h7FFF_FFFF;
      end else begin
        s.val = mag[31:0];
      end
    end else begin
      if (mag > 65'h0_8000_0000) begin
        s.ovf = 1'b1;
        s.val = 32'h8000_0000;
      end else begin
        s.val = 32'(-mag[31:0]);
      end
    end
    return s;
  endfunction

  function automatic lane_t lane_step(input lane_t l, input logic [63:0] den,
                                      input logic [4:0] pos);
    lane_t            o;
    logic [REM_W-1:0] t;
    o = l;
    t = {{(REM_W-64){1'b0}}, den} << pos;
    if (l.r >= t) begin
      o.r      = l.r - t;
      o.q[pos] = 1'b1;
    end
    return o;
  endfunction

endpackage

// File: design/cau_prod.sv
module cau_prod
  import cau_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  op_t   in_op,
  output logic  out_valid,
  input  logic  out_ready,
  output prod_t out_prod
);

  logic  v_r;
  prod_t prod_r;
  prod_t prod_nxt;

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_prod  = prod_r;

  always_comb begin
    prod_nxt.mode   = in_op.mode;
    prod_nxt.a_re   = in_op.a_re;
    prod_nxt.a_im   = in_op.a_im;
    prod_nxt.sum_re = {in_op.a_re[31], in_op.a_re} + {in_op.b_re[31], in_op.b_re};
    prod_nxt.sum_im = {in_op.a_im[31], in_op.a_im} + {in_op.b_im[31], in_op.b_im};
    prod_nxt.p_rr   = 64'($signed(in_op.a_re) * $signed(in_op.b_re));
    prod_nxt.p_ii   = 64'($signed(in_op.a_im) * $signed(in_op.b_im));
    prod_nxt.p_ri   = 64'($signed(in_op.a_re) * $signed(in_op.b_im));
    prod_nxt.p_ir   = 64'($signed(in_op.a_im) * $signed(in_op.b_re));
    prod_nxt.p_br2  = 64'($signed(in_op.b_re) * $signed(in_op.b_re));
    prod_nxt.p_bi2  = 64'($signed(in_op.b_im) * $signed(in_op.b_im));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// File: design/cau_prep.sv
module cau_prep
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = CAU_FRAC_BITS
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  prod_t in_prod,
  output logic  out_valid,
  input  logic  out_ready,
  output div_t  out_div
);

  typedef struct packed {
    mode_t       mode;
    logic [31:0] a_re;
    logic [31:0] a_im;
    logic [32:0] sum_re;
    logic [32:0] sum_im;
    logic [64:0] num_re;
    logic [64:0] num_im;
    logic [63:0] den;
  } num_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] a_re;
    logic [31:0] a_im;
    sat_t        add_re;
    sat_t        add_im;
    logic        neg_re;
    logic        neg_im;
    logic [63:0] mag_re;
    logic [63:0] mag_im;
    logic [63:0] den;
    logic        dz;
  } mag_t;

  localparam logic [64:0] RND = 65'((65'd1 << FRAC_BITS) - 65'd1);

  logic [2:0] v_r;
  logic [2:0] rdy;
  num_t       s2_r, s2_nxt;
  mag_t       s3_r, s3_nxt;
  div_t       s4_r, s4_nxt;

  assign rdy[2]    = !v_r[2] || out_ready;
  assign rdy[1]    = !v_r[1] || rdy[2];
  assign rdy[0]    = !v_r[0] || rdy[1];
  assign in_ready  = rdy[0];
  assign out_valid = v_r[2];
  assign out_div   = s4_r;

  // Numerators and |b|^2, formed exactly.
  always_comb begin
    logic [64:0] rr, ii, ri, ir;
    rr = {in_prod.p_rr[63], in_prod.p_rr};
    ii = {in_prod.p_ii[63], in_prod.p_ii};
    ri = {in_prod.p_ri[63], in_prod.p_ri};
    ir = {in_prod.p_ir[63], in_prod.p_ir};
    s2_nxt.mode   = in_prod.mode;
    s2_nxt.a_re   = in_prod.a_re;
    s2_nxt.a_im   = in_prod.a_im;
    s2_nxt.sum_re = in_prod.sum_re;
    s2_nxt.sum_im = in_prod.sum_im;
    if (in_prod.mode == MODE_MUL) begin
      s2_nxt.num_re = rr - ii;
      s2_nxt.num_im = ri + ir;
    end else begin
      s2_nxt.num_re = rr + ii;
      s2_nxt.num_im = ir - ri;
    end
    s2_nxt.den = in_prod.p_br2 + in_prod.p_bi2;
  end

  always_comb begin
    logic [64:0] se_re, se_im, nr, ni;
    se_re = {{32{s2_r.sum_re[32]}}, s2_r.sum_re};
    se_im = {{32{s2_r.sum_im[32]}}, s2_r.sum_im};
    nr    = -s2_r.num_re;
    ni    = -s2_r.num_im;
    s3_nxt.mode   = s2_r.mode;
    s3_nxt.a_re   = s2_r.a_re;
    s3_nxt.a_im   = s2_r.a_im;
    s3_nxt.add_re = sat_fn(s2_r.sum_re[32], s2_r.sum_re[32] ? -se_re : se_re);
    s3_nxt.add_im = sat_fn(s2_r.sum_im[32], s2_r.sum_im[32] ? -se_im : se_im);
    s3_nxt.neg_re = s2_r.num_re[64];
    s3_nxt.neg_im = s2_r.num_im[64];
    s3_nxt.mag_re = s2_r.num_re[64] ? nr[63:0] : s2_r.num_re[63:0];
    s3_nxt.mag_im = s2_r.num_im[64] ? ni[63:0] : s2_r.num_im[63:0];
    s3_nxt.den    = s2_r.den;
    s3_nxt.dz     = (s2_r.den == 64'd0);
  end

  // Early results for every case but a true divide, and divider setup.
  always_comb begin
    logic [64:0]      m_re, m_im;
    logic [REM_W-1:0] n_re, n_im, dtop;
    sat_t             mr, mi;
    m_re = {1'b0, s3_r.mag_re};
    m_im = {1'b0, s3_r.mag_im};
    if (s3_r.neg_re) m_re = m_re + RND;
    if (s3_r.neg_im) m_im = m_im + RND;
    mr   = sat_fn(s3_r.neg_re, m_re >> FRAC_BITS);
    mi   = sat_fn(s3_r.neg_im, m_im >> FRAC_BITS);
    n_re = {{(REM_W-64){1'b0}}, s3_r.mag_re} << FRAC_BITS;
    n_im = {{(REM_W-64){1'b0}}, s3_r.mag_im} << FRAC_BITS;
    dtop = {s3_r.den, {(REM_W-64){1'b0}}};

    s4_nxt.do_div    = 1'b0;
    s4_nxt.early_re  = 32'd0;
    s4_nxt.early_im  = 32'd0;
    s4_nxt.early_dz  = 1'b0;
    s4_nxt.early_ovf = 1'b0;
    s4_nxt.den       = s3_r.den;
    s4_nxt.re.neg    = s3_r.neg_re;
    s4_nxt.re.big    = (n_re >= dtop);
    s4_nxt.re.r      = n_re;
    s4_nxt.re.q      = 32'd0;
    s4_nxt.im.neg    = s3_r.neg_im;
    s4_nxt.im.big    = (n_im >= dtop);
    s4_nxt.im.r      = n_im;
    s4_nxt.im.q      = 32'd0;
    unique case (s3_r.mode)
      MODE_ADD: begin
        s4_nxt.early_re  = s3_r.add_re.val;
        s4_nxt.early_im  = s3_r.add_im.val;
        s4_nxt.early_ovf = s3_r.add_re.ovf || s3_r.add_im.ovf;
      end
      MODE_MUL: begin
        s4_nxt.early_re  = mr.val;
        s4_nxt.early_im  = mi.val;
        s4_nxt.early_ovf = mr.ovf || mi.ovf;
      end
      MODE_DIV: begin
        if (s3_r.dz) begin
          s4_nxt.early_re = s3_r.a_re;
          s4_nxt.early_im = s3_r.a_im;
          s4_nxt.early_dz = 1'b1;
        end else begin
          s4_nxt.do_div = 1'b1;
        end
      end
      MODE_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 3'b000;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) s2_r <= s2_nxt;
    if (rdy[1] && v_r[0])   s3_r <= s3_nxt;
    if (rdy[2] && v_r[1])   s4_r <= s4_nxt;
  end

endmodule

// File: design/cau_div.sv
module cau_div
  import cau_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  div_t in_div,
  output logic out_valid,
  input  logic out_ready,
  output div_t out_div
);

  logic [DIV_STEPS-1:0] v_r;
  logic [DIV_STEPS-1:0] rdy;
  div_t                 d_r [DIV_STEPS];

  assign in_ready  = rdy[0];
  assign out_valid = v_r[DIV_STEPS-1];
  assign out_div   = d_r[DIV_STEPS-1];

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic vin;
    div_t din;
    div_t d_nxt;

    if (k == 0) begin : g_first
      assign vin = in_valid;
      assign din = in_div;
    end else begin : g_next
      assign vin = v_r[k-1];
      assign din = d_r[k-1];
    end

    if (k == DIV_STEPS-1) begin : g_last
      assign rdy[k] = !v_r[k] || out_ready;
    end else begin : g_mid
      assign rdy[k] = !v_r[k] || rdy[k+1];
    end

    always_comb begin
      d_nxt    = din;
      d_nxt.re = lane_step(din.re, din.den, 5'(DIV_STEPS-1-k));
      d_nxt.im = lane_step(din.im, din.den, 5'(DIV_STEPS-1-k));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && vin) begin
        d_r[k] <= d_nxt;
      end
    end
  end

endmodule

// File: design/cau_out.sv
module cau_out
  import cau_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  div_t        in_div,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] res_re,
  output logic [31:0] res_im,
  output logic        div_zero,
  output logic        overflow
);

  logic        v_r;
  logic [31:0] re_r, re_nxt;
  logic [31:0] im_r, im_nxt;
  logic        dz_r, dz_nxt;
  logic        ovf_r, ovf_nxt;

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign res_re    = re_r;
  assign res_im    = im_r;
  assign div_zero  = dz_r;
  assign overflow  = ovf_r;

  always_comb begin
    sat_t qr, qi;
    // A quotient flagged big is past 32 bits, so any value above the limits saturates.
    qr = sat_fn(in_div.re.neg, in_div.re.big ? 65'h1_0000_0000 : {33'd0, in_div.re.q});
    qi = sat_fn(in_div.im.neg, in_div.im.big ? 65'h1_0000_0000 : {33'd0, in_div.im.q});
    if (in_div.do_div) begin
      re_nxt  = qr.val;
      im_nxt  = qi.val;
      dz_nxt  = 1'b0;
      ovf_nxt = qr.ovf || qi.ovf;
    end else begin
      re_nxt  = in_div.early_re;
      im_nxt  = in_div.early_im;
      dz_nxt  = in_div.early_dz;
      ovf_nxt = in_div.early_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      re_r  <= re_nxt;
      im_r  <= im_nxt;
      dz_r  <= dz_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

// File: design/complex_arith_unit.sv
// Complex add, multiply and divide on signed fixed-point operands.
//
// Input stream: each beat on in_tdata carries a mode and two complex operands a
// and b. Mode add returns a+b, multiply returns a*b with the product shifted down
// by FRAC_BITS (rounded toward minus infinity), divide returns a/b truncated
// toward zero. Every result part saturates to 32 bits and raises overflow. A
// divide by zero returns a unchanged with div_zero set; the unused mode returns 0.
//
// Output stream: one beat on out_tdata per input beat, in order.
//
// The pipe has 37 register stages: one multiplier stage, three stages of sums,
// sign and range checks, 32 divider stages (one quotient bit each) and the
// output register. Every mode takes the same path. Throughput is one beat per
// cycle; each stage has its own valid bit, so empty stages fill while
// out_tready is low and only a full pipe stops in_tready.
//
// Reset clears all valid bits; nothing in flight survives it. A stall holds the
// waiting result on out_tdata until it is taken.
module complex_arith_unit
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = CAU_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // mode[1:0], a_re[33:2], a_im[65:34], b_re[97:66], b_im[129:98], zero fill
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // res_re[31:0], res_im[63:32], div_zero[64], overflow[65], zero fill
  output logic [71:0]  out_tdata
);

  op_t         op;
  prod_t       prod;
  div_t        prep_div;
  div_t        fin_div;
  logic        prod_valid, prod_ready;
  logic        prep_valid, prep_ready;
  logic        div_valid, div_ready;
  logic [31:0] res_re, res_im;
  logic        div_zero, overflow;

  assign op.mode = mode_t'(in_tdata[1:0]);
  assign op.a_re = in_tdata[33:2];
  assign op.a_im = in_tdata[65:34];
  assign op.b_re = in_tdata[97:66];
  assign op.b_im = in_tdata[129:98];

  assign out_tdata = {6'd0, overflow, div_zero, res_im, res_re};

  cau_prod u_prod (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (op),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_prod  (prod)
  );

  cau_prep #(
    .FRAC_BITS (FRAC_BITS)
  ) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_prod   (prod),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .out_div   (prep_div)
  );

  cau_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_div    (prep_div),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_div   (fin_div)
  );

  cau_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_div    (fin_div),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_re    (res_re),
    .res_im    (res_im),
    .div_zero  (div_zero),
    .overflow  (overflow)
  );

endmodule

// File: design/cau_checker.sv
module cau_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output beat changed");

  a_flags_apart: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[64] && out_tdata[65]))
    else $error("div_zero and overflow both set");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[65] |->
      out_tdata[31:0] == 32'h7FFF_FFFF || out_tdata[31:0] == 32'h8000_0000 ||
      out_tdata[63:32] == 32'h7FFF_FFFF || out_tdata[63:32] == 32'h8000_0000)
    else $error("overflow without a saturated part");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output register empty");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (.*);

// File: dv/complex_arith_unit_tb.sv
module complex_arith_unit_tb;
  import cau_pkg::*;

  localparam int LATENCY   = 37;
  localparam int WDOG_MAX  = 20000;
  localparam int FRAC      = CAU_FRAC_BITS;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        dz;
    logic        ovf;
  } cplx_res_t;

  typedef struct {
    mode_t       mode;
    logic [31:0] a_re;
    logic [31:0] a_im;
    logic [31:0] b_re;
    logic [31:0] b_im;
    logic        has_exp;
    cplx_res_t   exp_res;
  } vec_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [71:0]  out_tdata;

  cplx_res_t    pending_q[$];
  int           fail_cnt;
  int           idle_cycles;
  int           src_idle_pct;
  int           snk_stall_pct;

  complex_arith_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Clamp a sign/magnitude pair to 32 bits.
  function automatic logic [31:0] clamp32(input logic neg, input logic [127:0] mag,
                                          inout logic ovf);
    if (!neg) begin
      if (mag > 128'h7FFF_FFFF) begin
        ovf = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return mag[31:0];
    end
    if (mag > 128'h8000_0000) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return 32'(-mag[31:0]);
  endfunction

  function automatic cplx_res_t complex_result(input mode_t mode, input logic [31:0] ar_u,
                                               input logic [31:0] ai_u, input logic [31:0] br_u,
                                               input logic [31:0] bi_u);
    cplx_res_t   r;
    logic signed [127:0] ar, ai, br, bi, nre, nim, den, mag, q;
    logic        ovf;
    ar = 128'(signed'(ar_u));
    ai = 128'(signed'(ai_u));
    br = 128'(signed'(br_u));
    bi = 128'(signed'(bi_u));
    ovf = 1'b0;
    r = '0;
    case (mode)
      MODE_ADD: begin
        nre = ar + br;
        nim = ai + bi;
        r.re = clamp32(nre < 0, nre < 0 ? -nre : nre, ovf);
        r.im = clamp32(nim < 0, nim < 0 ? -nim : nim, ovf);
      end
      MODE_MUL: begin
        // Arithmetic shift gives the floor toward minus infinity.
        nre = (ar * br - ai * bi) >>> FRAC;
        nim = (ar * bi + ai * br) >>> FRAC;
        r.re = clamp32(nre < 0, nre < 0 ? -nre : nre, ovf);
        r.im = clamp32(nim < 0, nim < 0 ? -nim : nim, ovf);
      end
      MODE_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.dz = 1'b1;
          r.re = ar_u;
          r.im = ai_u;
        end else begin
          nre = ar * br + ai * bi;
          mag = nre < 0 ? -nre : nre;
          q = (mag << FRAC) / den;
          r.re = clamp32(nre < 0, q, ovf);
          nim = ai * br - ar * bi;
          mag = nim < 0 ? -nim : nim;
          q = (mag << FRAC) / den;
          r.im = clamp32(nim < 0, q, ovf);
        end
      end
      default: r = '0;
    endcase
    r.ovf = ovf;
    return r;
  endfunction

  function automatic logic [31:0] rand_part();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'($signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
      3: return 32'($signed($urandom_range(0, 512)) - 256);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_op(input mode_t mode, input logic [31:0] ar, input logic [31:0] ai,
                         input logic [31:0] br, input logic [31:0] bi,
                         input logic has_exp, input cplx_res_t exp_res);
    cplx_res_t pred;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, bi, br, ai, ar, mode};
    pred = complex_result(mode, ar, ai, br, bi);
    if (has_exp && pred !== exp_res) begin
      $error("table row disagrees with predictor: mode %0d table %h predictor %h",
             mode, exp_res, pred);
      fail_cnt++;
    end
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_q.push_back(has_exp ? exp_res : pred);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    cplx_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.re  = out_tdata[31:0];
      got.im  = out_tdata[63:32];
      got.dz  = out_tdata[64];
      got.ovf = out_tdata[65];
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        fail_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (got.re !== want.re) begin
          $error("res_re expected %h actual %h", want.re, got.re);
          fail_cnt++;
        end
        if (got.im !== want.im) begin
          $error("res_im expected %h actual %h", want.im, got.im);
          fail_cnt++;
        end
        if (got.dz !== want.dz) begin
          $error("div_zero expected %b actual %b", want.dz, got.dz);
          fail_cnt++;
        end
        if (got.ovf !== want.ovf) begin
          $error("overflow expected %b actual %b", want.ovf, got.ovf);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted beat on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  vec_t dir_tbl[$];

  task automatic add_row(input mode_t m, input logic [31:0] ar, input logic [31:0] ai,
                         input logic [31:0] br, input logic [31:0] bi,
                         input logic he, input cplx_res_t er);
    vec_t v;
    v.mode = m; v.a_re = ar; v.a_im = ai; v.b_re = br; v.b_im = bi;
    v.has_exp = he; v.exp_res = er;
    dir_tbl.push_back(v);
  endtask

  initial begin
    mode_t m;
    int    n;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    fail_cnt      = 0;
    idle_cycles   = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_row(MODE_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 1,
            '{32'h0004_0000, 32'h0001_0000, 1'b0, 1'b0});
    add_row(MODE_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 1,
            '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1});
    add_row(MODE_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1,
            '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1});
    add_row(MODE_MUL, 32'h0002_0000, 32'h0000_0000, 32'h0003_0000, 32'h0000_0000, 1,
            '{32'h0006_0000, 32'h0000_0000, 1'b0, 1'b0});
    add_row(MODE_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1,
            '{32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1});
    add_row(MODE_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h0, 0, '0);
    add_row(MODE_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, '0);
    add_row(MODE_DIV, 32'h1234_5678, 32'h8000_0000, 32'h0, 32'h0, 1,
            '{32'h1234_5678, 32'h8000_0000, 1'b1, 1'b0});
    add_row(MODE_DIV, 32'h0006_0000, 32'h0000_0000, 32'h0002_0000, 32'h0000_0000, 1,
            '{32'h0003_0000, 32'h0000_0000, 1'b0, 1'b0});
    add_row(MODE_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0, 1,
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1});
    add_row(MODE_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, '0);
    add_row(MODE_DIV, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0003_0000, 32'hFFFD_0000, 0, '0);
    add_row(MODE_DIV, 32'h0001_0000, 32'h0, 32'h0000_0001, 32'h0000_0001, 0, '0);
    add_row(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
            '{32'h0, 32'h0, 1'b0, 1'b0});
    add_row(MODE_ADD, 32'h0, 32'h0, 32'h0, 32'h0, 1, '{32'h0, 32'h0, 1'b0, 1'b0});

    foreach (dir_tbl[i])
      send_op(dir_tbl[i].mode, dir_tbl[i].a_re, dir_tbl[i].a_im, dir_tbl[i].b_re,
              dir_tbl[i].b_im, dir_tbl[i].has_exp, dir_tbl[i].exp_res);
    in_tvalid <= 1'b0;

    // Hold off until the pipe has drained once.
    while (pending_q.size() != 0) @(negedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 70; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 70; end
        default: begin src_idle_pct = 31; snk_stall_pct = 31; end
      endcase
      for (n = 0; n < 110; n++) begin
        m = mode_t'($urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 2));
        if (m == MODE_DIV && $urandom_range(0, 9) == 0)
          send_op(m, rand_part(), rand_part(), 32'h0, 32'h0, 0, '0);
        else
          send_op(m, rand_part(), rand_part(), rand_part(), rand_part(), 0, '0);
      end
    end
    in_tvalid     <= 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;

    while (pending_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/cau_pkg.sv
design/cau_prod.sv
design/cau_prep.sv
design/cau_div.sv
design/cau_out.sv
design/complex_arith_unit.sv
design/cau_checker.sv
dv/complex_arith_unit_tb.sv
